// ----- src/cle_pkg.sv -----
// Shared types, constants and helpers for the circular list engine.
// No dependencies; every other file refers to this package by scoped names.
package cle_pkg;

	// List storage geometry
	localparam int DEPTH  = 16;
	localparam int AW     = $clog2(DEPTH);
	localparam int CW     = $clog2(DEPTH + 1);

	// Field widths
	localparam int DATA_W = 32;
	localparam int CMD_W  = 3;
	localparam int POS_W  = 8;
	localparam int STAT_W = 2;
	localparam int STEP_W = $clog2(POS_W);

	// Command queue between front and back
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// Command codes on the request channel
	typedef enum logic [CMD_W-1:0] {
		CMD_INS_END   = 3'd0,
		CMD_INS_FRONT = 3'd1,
		CMD_INS_POS   = 3'd2,
		CMD_DEL_END   = 3'd3,
		CMD_DEL_FRONT = 3'd4,
		CMD_DUMP      = 3'd5
	} cmd_t;

	// Result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Decoded operations handed from front to back
	typedef enum logic [2:0] {
		OP_INS_END,
		OP_INS_FRONT,
		OP_INS_MID,
		OP_DEL_END,
		OP_DEL_FRONT,
		OP_DUMP,
		OP_REPORT
	} op_kind_t;

	typedef struct packed {
		op_kind_t                  kind;
		status_t                   status;
		logic signed [DATA_W-1:0]  value;
		logic [CW-1:0]             target;
	} op_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SHIFT_RD,
		B_SHIFT_WR,
		B_PLACE,
		B_EMIT,
		B_DUMP
	} back_state_t;

	// Physical slot of a logical position, ring rooted at base
	function automatic logic [AW-1:0] wrap_idx(input logic [AW-1:0] base,
		input logic [CW-1:0] off);
		logic [CW:0] sum;
		sum = (CW+1)'(base) + (CW+1)'(off);
		if (sum >= (CW+1)'(DEPTH)) begin
			sum = sum - (CW+1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

endpackage

// ----- src/cle_chan_if.sv -----
// Valid/ready channel interfaces for the circular list engine.
// Depends on cle_pkg for field widths and types.
interface cle_req_if;
	logic                                 valid;
	logic                                 ready;
	logic [cle_pkg::CMD_W-1:0]            cmd;
	logic signed [cle_pkg::DATA_W-1:0]    item_value;
	logic [cle_pkg::POS_W-1:0]            position;

	modport source (output valid, cmd, item_value, position, input ready);
	modport sink   (input valid, cmd, item_value, position, output ready);
endinterface

interface cle_rsp_if;
	logic                                 valid;
	logic                                 ready;
	cle_pkg::status_t                     status;
	logic signed [cle_pkg::DATA_W-1:0]    out_value;
	logic                                 last;

	modport source (output valid, status, out_value, last, input ready);
	modport sink   (input valid, status, out_value, last, output ready);
endinterface

// ----- src/circular_list_engine_unit.sv -----
// Top level of the circular list engine: front end, operation queue, back end.
// Depends on cle_pkg, cle_chan_if, cle_fifo, cle_front and cle_back.
//
//   channel | dir | fields                          | accepted when
//   --------+-----+---------------------------------+---------------------
//   req     | in  | cmd, item_value, position       | req.valid & req.ready
//   rsp     | out | status, out_value, last         | rsp.valid & rsp.ready
//
// Simple commands: the queue holds the operation; the back end pops it from the queue,
// then loads the response register. Reset empties the list at once.
// Insert at position above one: front busy for 8 remainder steps, then a push step;
// back reads and rewrites each entry moved down the ring, then places the new value.
// Dump: one transaction per cycle once started, while rsp.ready stays high.
// A held response stalls the back end; req.ready drops once the 2-entry queue fills.
module circular_list_engine_unit (
	input  logic        clk,
	input  logic        arst_n,
	cle_req_if.sink     req,
	cle_rsp_if.source   rsp
);

	logic           push;
	logic           q_full;
	logic           pop;
	logic           q_empty;
	cle_pkg::op_t   push_data;
	cle_pkg::op_t   pop_data;

	cle_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	cle_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	cle_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (pop_data),
		.pop     (pop),
		.rsp     (rsp)
	);

endmodule

// ----- src/cle_fifo.sv -----
// Short register queue of decoded operations between front and back.
// Depends on cle_pkg for op_t and the queue depth.
module cle_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cle_pkg::op_t   push_data,
	output logic           full,
	input  logic           pop,
	output cle_pkg::op_t   pop_data,
	output logic           empty
);

	cle_pkg::op_t                   slots [cle_pkg::FIFO_DEPTH];
	logic [cle_pkg::FIFO_AW-1:0]    wr_ptr_q;
	logic [cle_pkg::FIFO_AW-1:0]    rd_ptr_q;
	logic [cle_pkg::FIFO_CW-1:0]    fill_q;
	logic [cle_pkg::FIFO_AW-1:0]    wr_ptr_nx;
	logic [cle_pkg::FIFO_AW-1:0]    rd_ptr_nx;

	// Flags
	assign full     = (fill_q == cle_pkg::FIFO_CW'(cle_pkg::FIFO_DEPTH));
	assign empty    = (fill_q == '0);
	assign pop_data = slots[rd_ptr_q];

	// Pointer wrap
	assign wr_ptr_nx = (wr_ptr_q == cle_pkg::FIFO_AW'(cle_pkg::FIFO_DEPTH - 1)) ? '0 :
		wr_ptr_q + cle_pkg::FIFO_AW'(1);
	assign rd_ptr_nx = (rd_ptr_q == cle_pkg::FIFO_AW'(cle_pkg::FIFO_DEPTH - 1)) ? '0 :
		rd_ptr_q + cle_pkg::FIFO_AW'(1);

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_nx;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_nx;
			end
			unique case ({push, pop})
				2'b10:   fill_q <= fill_q + cle_pkg::FIFO_CW'(1);
				2'b01:   fill_q <= fill_q - cle_pkg::FIFO_CW'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

	// Slot storage
	always_ff @(posedge clk) begin
		if (push) begin
			slots[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- src/cle_front.sv -----
// Front end: accepts request transactions, tracks the list length ahead of
// the back end, resolves status and insert position. Depends on cle_pkg.
module cle_front (
	input  logic           clk,
	input  logic           arst_n,
	cle_req_if.sink        req,
	output logic           push,
	output cle_pkg::op_t   push_data,
	input  logic           q_full
);

	cle_pkg::front_state_t          state_q;
	cle_pkg::front_state_t          state_d;
	logic [cle_pkg::CW-1:0]         cnt_q;
	logic [cle_pkg::POS_W-1:0]      dvd_q;
	logic [cle_pkg::CW-1:0]         div_q;
	logic [cle_pkg::CW-1:0]         rem_q;
	logic [cle_pkg::STEP_W-1:0]     step_q;
	logic signed [cle_pkg::DATA_W-1:0] val_q;

	logic                           accept;
	logic                           dec_push;
	logic                           dec_div;
	cle_pkg::op_t                   dec_op;
	logic [cle_pkg::CW:0]           trial;
	logic [cle_pkg::CW:0]           diff;
	logic [cle_pkg::CW-1:0]         rem_nx;
	logic                           cnt_inc;
	logic                           cnt_dec;

	assign accept = req.valid && req.ready;

	// Classify the incoming command against the tracked length
	always_comb begin
		dec_push      = 1'b0;
		dec_div       = 1'b0;
		dec_op.kind   = cle_pkg::OP_REPORT;
		dec_op.status = cle_pkg::ST_OK;
		dec_op.value  = req.item_value;
		dec_op.target = cle_pkg::CW'(1);
		unique case (req.cmd)
			cle_pkg::CMD_INS_END, cle_pkg::CMD_INS_FRONT, cle_pkg::CMD_INS_POS: begin
				if (cnt_q == cle_pkg::CW'(cle_pkg::DEPTH)) begin
					dec_push      = 1'b1;
					dec_op.status = cle_pkg::ST_FULL;
				end else if (cnt_q == '0 || req.cmd == cle_pkg::CMD_INS_END) begin
					dec_push    = 1'b1;
					dec_op.kind = cle_pkg::OP_INS_END;
				end else if (req.cmd == cle_pkg::CMD_INS_FRONT) begin
					dec_push    = 1'b1;
					dec_op.kind = cle_pkg::OP_INS_FRONT;
				end else if (req.position <= cle_pkg::POS_W'(1)) begin
					dec_push    = 1'b1;
					dec_op.kind = cle_pkg::OP_INS_MID;
				end else begin
					dec_div = 1'b1;
				end
			end
			cle_pkg::CMD_DEL_END, cle_pkg::CMD_DEL_FRONT: begin
				dec_push = 1'b1;
				if (cnt_q == '0) begin
					dec_op.status = cle_pkg::ST_EMPTY;
				end else if (req.cmd == cle_pkg::CMD_DEL_END) begin
					dec_op.kind = cle_pkg::OP_DEL_END;
				end else begin
					dec_op.kind = cle_pkg::OP_DEL_FRONT;
				end
			end
			cle_pkg::CMD_DUMP: begin
				dec_push = 1'b1;
				if (cnt_q == '0) begin
					dec_op.status = cle_pkg::ST_EMPTY;
				end else begin
					dec_op.kind = cle_pkg::OP_DUMP;
				end
			end
			default: begin
				dec_push = 1'b0;
			end
		endcase
	end

	// One restoring remainder step per cycle
	assign trial  = {rem_q, dvd_q[cle_pkg::POS_W-1]};
	assign diff   = trial - {1'b0, div_q};
	assign rem_nx = (trial >= {1'b0, div_q}) ? diff[cle_pkg::CW-1:0] : trial[cle_pkg::CW-1:0];

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cle_pkg::F_IDLE: begin
				if (accept && dec_div) begin
					state_d = cle_pkg::F_DIV;
				end
			end
			cle_pkg::F_DIV: begin
				if (step_q == cle_pkg::STEP_W'(cle_pkg::POS_W - 1)) begin
					state_d = cle_pkg::F_PUSH;
				end
			end
			cle_pkg::F_PUSH: begin
				if (!q_full) begin
					state_d = cle_pkg::F_IDLE;
				end
			end
			default: state_d = cle_pkg::F_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		req.ready = 1'b0;
		push      = 1'b0;
		push_data = dec_op;
		unique case (state_q)
			cle_pkg::F_IDLE: begin
				req.ready = !q_full;
				push      = accept && dec_push;
			end
			cle_pkg::F_PUSH: begin
				push             = !q_full;
				push_data.kind   = cle_pkg::OP_INS_MID;
				push_data.status = cle_pkg::ST_OK;
				push_data.value  = val_q;
				push_data.target = rem_q + cle_pkg::CW'(1);
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	// Tracked length follows every queued operation
	assign cnt_inc = push && (push_data.kind == cle_pkg::OP_INS_END ||
		push_data.kind == cle_pkg::OP_INS_FRONT || push_data.kind == cle_pkg::OP_INS_MID);
	assign cnt_dec = push && (push_data.kind == cle_pkg::OP_DEL_END ||
		push_data.kind == cle_pkg::OP_DEL_FRONT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cle_pkg::F_IDLE;
			cnt_q   <= '0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cnt_inc) begin
				cnt_q <= cnt_q + cle_pkg::CW'(1);
			end else if (cnt_dec) begin
				cnt_q <= cnt_q - cle_pkg::CW'(1);
			end
			if (state_q == cle_pkg::F_DIV) begin
				step_q <= step_q + cle_pkg::STEP_W'(1);
			end else begin
				step_q <= '0;
			end
		end
	end

	// Remainder unit datapath: (position - 1) mod length
	always_ff @(posedge clk) begin
		if (state_q == cle_pkg::F_IDLE && accept && dec_div) begin
			dvd_q <= req.position - cle_pkg::POS_W'(1);
			div_q <= cnt_q;
			rem_q <= '0;
			val_q <= req.item_value;
		end else if (state_q == cle_pkg::F_DIV) begin
			dvd_q <= {dvd_q[cle_pkg::POS_W-2:0], 1'b0};
			rem_q <= rem_nx;
		end
	end

endmodule

// ----- src/cle_back.sv -----
// Back end: ring-buffer list store, executes decoded operations and drives
// the response register. Depends on cle_pkg and cle_chan_if.
module cle_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  cle_pkg::op_t   q_data,
	output logic           pop,
	cle_rsp_if.source      rsp
);

	cle_pkg::back_state_t              state_q;
	cle_pkg::back_state_t              state_d;
	cle_pkg::op_t                      op_q;
	logic [cle_pkg::AW-1:0]            head_q;
	logic [cle_pkg::CW-1:0]            cnt_q;
	logic [cle_pkg::CW-1:0]            i_q;
	logic signed [cle_pkg::DATA_W-1:0] mem [cle_pkg::DEPTH];
	logic signed [cle_pkg::DATA_W-1:0] rd_q;

	logic                              ovld_q;
	cle_pkg::status_t                  ostat_q;
	logic signed [cle_pkg::DATA_W-1:0] oval_q;
	logic                              olast_q;

	logic                              slot_free;
	logic                              dump_last;
	logic [cle_pkg::AW-1:0]            head_m1;
	logic [cle_pkg::AW-1:0]            head_p1;

	logic                              we;
	logic [cle_pkg::AW-1:0]            wa;
	logic signed [cle_pkg::DATA_W-1:0] wd;
	logic                              re;
	logic [cle_pkg::AW-1:0]            ra;
	logic                              load;
	cle_pkg::status_t                  ld_stat;
	logic                              ld_use_rd;
	logic                              ld_last;
	logic                              cnt_inc;
	logic                              cnt_dec;
	logic                              head_inc;
	logic                              head_dec;
	logic                              i_load;
	logic [cle_pkg::CW-1:0]            i_val;
	logic                              i_inc;
	logic                              i_dec;

	assign slot_free = !ovld_q || rsp.ready;
	assign dump_last = (i_q + cle_pkg::CW'(1) == cnt_q);
	assign head_m1   = (head_q == '0) ? cle_pkg::AW'(cle_pkg::DEPTH - 1) :
		head_q - cle_pkg::AW'(1);
	assign head_p1   = (head_q == cle_pkg::AW'(cle_pkg::DEPTH - 1)) ? '0 :
		head_q + cle_pkg::AW'(1);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cle_pkg::B_IDLE: begin
				if (!q_empty) begin
					unique case (q_data.kind)
						cle_pkg::OP_INS_MID: begin
							state_d = (q_data.target == cnt_q) ? cle_pkg::B_EMIT :
								cle_pkg::B_SHIFT_RD;
						end
						cle_pkg::OP_DUMP: state_d = cle_pkg::B_DUMP;
						default:          state_d = cle_pkg::B_EMIT;
					endcase
				end
			end
			cle_pkg::B_SHIFT_RD: state_d = cle_pkg::B_SHIFT_WR;
			cle_pkg::B_SHIFT_WR: begin
				if (i_q == op_q.target) begin
					state_d = cle_pkg::B_PLACE;
				end else begin
					state_d = cle_pkg::B_SHIFT_RD;
				end
			end
			cle_pkg::B_PLACE: state_d = cle_pkg::B_EMIT;
			cle_pkg::B_EMIT: begin
				if (slot_free) begin
					state_d = cle_pkg::B_IDLE;
				end
			end
			cle_pkg::B_DUMP: begin
				if (slot_free && dump_last) begin
					state_d = cle_pkg::B_IDLE;
				end
			end
			default: state_d = cle_pkg::B_IDLE;
		endcase
	end

	// Datapath controls per state
	always_comb begin
		pop       = 1'b0;
		we        = 1'b0;
		wa        = '0;
		wd        = q_data.value;
		re        = 1'b0;
		ra        = '0;
		load      = 1'b0;
		ld_stat   = cle_pkg::ST_OK;
		ld_use_rd = 1'b0;
		ld_last   = 1'b1;
		cnt_inc   = 1'b0;
		cnt_dec   = 1'b0;
		head_inc  = 1'b0;
		head_dec  = 1'b0;
		i_load    = 1'b0;
		i_val     = '0;
		i_inc     = 1'b0;
		i_dec     = 1'b0;
		unique case (state_q)
			cle_pkg::B_IDLE: begin
				if (!q_empty) begin
					pop = 1'b1;
					unique case (q_data.kind)
						cle_pkg::OP_INS_END: begin
							we      = 1'b1;
							wa      = cle_pkg::wrap_idx(head_q, cnt_q);
							cnt_inc = 1'b1;
						end
						cle_pkg::OP_INS_FRONT: begin
							we       = 1'b1;
							wa       = head_m1;
							head_dec = 1'b1;
							cnt_inc  = 1'b1;
						end
						cle_pkg::OP_INS_MID: begin
							if (q_data.target == cnt_q) begin
								we      = 1'b1;
								wa      = cle_pkg::wrap_idx(head_q, cnt_q);
								cnt_inc = 1'b1;
							end else begin
								i_load = 1'b1;
								i_val  = cnt_q - cle_pkg::CW'(1);
							end
						end
						cle_pkg::OP_DEL_END: begin
							re      = 1'b1;
							ra      = cle_pkg::wrap_idx(head_q, cnt_q - cle_pkg::CW'(1));
							cnt_dec = 1'b1;
						end
						cle_pkg::OP_DEL_FRONT: begin
							re       = 1'b1;
							ra       = head_q;
							head_inc = 1'b1;
							cnt_dec  = 1'b1;
						end
						cle_pkg::OP_DUMP: begin
							re     = 1'b1;
							ra     = head_q;
							i_load = 1'b1;
						end
						default: begin
							re = 1'b0;
						end
					endcase
				end
			end
			// move entry i one slot towards the end
			cle_pkg::B_SHIFT_RD: begin
				re = 1'b1;
				ra = cle_pkg::wrap_idx(head_q, i_q);
			end
			cle_pkg::B_SHIFT_WR: begin
				we = 1'b1;
				wa = cle_pkg::wrap_idx(head_q, i_q + cle_pkg::CW'(1));
				wd = rd_q;
				i_dec = (i_q != op_q.target);
			end
			cle_pkg::B_PLACE: begin
				we      = 1'b1;
				wa      = cle_pkg::wrap_idx(head_q, op_q.target);
				wd      = op_q.value;
				cnt_inc = 1'b1;
			end
			cle_pkg::B_EMIT: begin
				load      = slot_free;
				ld_stat   = op_q.status;
				ld_use_rd = (op_q.kind == cle_pkg::OP_DEL_END ||
					op_q.kind == cle_pkg::OP_DEL_FRONT);
			end
			// emit entry i and fetch entry i+1 in the same cycle
			cle_pkg::B_DUMP: begin
				load      = slot_free;
				ld_use_rd = 1'b1;
				ld_last   = dump_last;
				if (slot_free && !dump_last) begin
					re    = 1'b1;
					ra    = cle_pkg::wrap_idx(head_q, i_q + cle_pkg::CW'(1));
					i_inc = 1'b1;
				end
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cle_pkg::B_IDLE;
			head_q  <= '0;
			cnt_q   <= '0;
			i_q     <= '0;
			ovld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (head_inc) begin
				head_q <= head_p1;
			end else if (head_dec) begin
				head_q <= head_m1;
			end
			if (cnt_inc) begin
				cnt_q <= cnt_q + cle_pkg::CW'(1);
			end else if (cnt_dec) begin
				cnt_q <= cnt_q - cle_pkg::CW'(1);
			end
			if (i_load) begin
				i_q <= i_val;
			end else if (i_inc) begin
				i_q <= i_q + cle_pkg::CW'(1);
			end else if (i_dec) begin
				i_q <= i_q - cle_pkg::CW'(1);
			end
			if (load) begin
				ovld_q <= 1'b1;
			end else if (rsp.ready) begin
				ovld_q <= 1'b0;
			end
		end
	end

	// Operation and response payload
	always_ff @(posedge clk) begin
		if (pop) begin
			op_q <= q_data;
		end
		if (load) begin
			ostat_q <= ld_stat;
			oval_q  <= ld_use_rd ? rd_q : '0;
			olast_q <= ld_last;
		end
	end

	// List store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd_q <= mem[ra];
		end
	end

	assign rsp.valid     = ovld_q;
	assign rsp.status    = ostat_q;
	assign rsp.out_value = oval_q;
	assign rsp.last      = olast_q;

`ifndef SYNTHESIS
	// shifting stays between the insert point and the current end
	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cle_pkg::B_SHIFT_RD) |-> (i_q >= op_q.target && i_q < cnt_q))
		else $error("shift index outside list");

	// a dump never walks past the stored entries
	a_dump_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cle_pkg::B_DUMP) |-> (i_q < cnt_q))
		else $error("dump index outside list");

	// a delete that reaches the store always shortens the list by one
	a_del_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cle_pkg::B_IDLE && !q_empty && (q_data.kind == cle_pkg::OP_DEL_END ||
		q_data.kind == cle_pkg::OP_DEL_FRONT)) |=> (cnt_q == $past(cnt_q) - cle_pkg::CW'(1)))
		else $error("delete did not shorten list");
`endif

endmodule

// ----- tb/tb_circular_list_engine_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for circular_list_engine_unit: directed table, then random traffic.
// Depends on cle_pkg, the cle_req_if / cle_rsp_if channel interfaces and the RTL top level.
module tb_circular_list_engine_unit;

	localparam int N_RANDOM   = 500;
	localparam int DRAIN_WAIT = 64;
	localparam logic [cle_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
	localparam logic [cle_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

	typedef struct packed {
		cle_pkg::status_t                  status;
		logic signed [cle_pkg::DATA_W-1:0] value;
		logic                              last;
	} rsp_t;

	typedef struct packed {
		logic [cle_pkg::CMD_W-1:0]         cmd;
		logic signed [cle_pkg::DATA_W-1:0] value;
		logic [cle_pkg::POS_W-1:0]         pos;
		logic                              typed;
		rsp_t                              exp;
	} stim_row_t;

	localparam rsp_t RSP_OK    = '{cle_pkg::ST_OK, 32'sd0, 1'b1};
	localparam rsp_t RSP_FULL  = '{cle_pkg::ST_FULL, 32'sd0, 1'b1};
	localparam rsp_t RSP_EMPTY = '{cle_pkg::ST_EMPTY, 32'sd0, 1'b1};

	logic clk;
	logic arst_n;

	cle_req_if req_ch ();
	cle_rsp_if rsp_ch ();

	circular_list_engine_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Directed table: edge cases on an empty list, wrap-round positions, then a fill to full
	stim_row_t dir_rows [0:27] = '{
		'{cle_pkg::CMD_DUMP,      32'sd0,         8'd0,   1'b1, RSP_EMPTY},
		'{cle_pkg::CMD_DEL_END,   32'sd0,         8'd0,   1'b1, RSP_EMPTY},
		'{cle_pkg::CMD_DEL_FRONT, 32'sd0,         8'd0,   1'b1, RSP_EMPTY},
		'{cle_pkg::CMD_INS_POS,   32'sh7FFF_FFFF, 8'd255, 1'b1, RSP_OK},
		'{cle_pkg::CMD_DEL_FRONT, 32'sd0,         8'd0,   1'b1,
			'{cle_pkg::ST_OK, 32'sh7FFF_FFFF, 1'b1}},
		'{cle_pkg::CMD_INS_FRONT, 32'sh8000_0000, 8'd0,   1'b1, RSP_OK},
		'{cle_pkg::CMD_DEL_END,   32'sd0,         8'd0,   1'b1,
			'{cle_pkg::ST_OK, 32'sh8000_0000, 1'b1}},
		'{CMD_SPARE_7,            32'shFFFF_FFFF, 8'd255, 1'b0, RSP_OK},
		'{CMD_SPARE_6,            32'sd0,         8'd0,   1'b0, RSP_OK},
		'{cle_pkg::CMD_INS_END,   32'shFFFF_FFFF, 8'd0,   1'b1, RSP_OK},
		'{cle_pkg::CMD_INS_POS,   32'sd1,         8'd0,   1'b1, RSP_OK},
		'{cle_pkg::CMD_INS_POS,   32'sd2,         8'd1,   1'b0, RSP_OK},
		'{cle_pkg::CMD_INS_FRONT, 32'sd3,         8'd0,   1'b0, RSP_OK},
		'{cle_pkg::CMD_INS_POS,   32'sd4,         8'd255, 1'b0, RSP_OK},
		'{cle_pkg::CMD_INS_POS,   32'sd5,         8'd2,   1'b0, RSP_OK},
		'{cle_pkg::CMD_INS_POS,   32'sd6,         8'd128, 1'b0, RSP_OK},
		'{cle_pkg::CMD_INS_END,   32'sh7FFF_FFFF, 8'd0,   1'b0, RSP_OK},
		'{cle_pkg::CMD_INS_FRONT, 32'sh8000_0000, 8'd0,   1'b0, RSP_OK},
		'{cle_pkg::CMD_DUMP,      32'sd0,         8'd0,   1'b0, RSP_OK},
		'{cle_pkg::CMD_INS_POS,   32'sd7,         8'd9,   1'b0, RSP_OK},
		'{cle_pkg::CMD_INS_POS,   32'sd8,         8'd10,  1'b0, RSP_OK},
		'{cle_pkg::CMD_INS_POS,   32'sd9,         8'd200, 1'b0, RSP_OK},
		'{cle_pkg::CMD_INS_END,   32'sd10,        8'd0,   1'b0, RSP_OK},
		'{cle_pkg::CMD_INS_FRONT, 32'sd11,        8'd0,   1'b0, RSP_OK},
		'{cle_pkg::CMD_INS_POS,   32'sd12,        8'd3,   1'b0, RSP_OK},
		'{cle_pkg::CMD_INS_END,   32'sh5555_5555, 8'd0,   1'b0, RSP_OK},
		'{cle_pkg::CMD_INS_POS,   32'shAAAA_AAAA, 8'd77,  1'b1, RSP_FULL},
		'{cle_pkg::CMD_DUMP,      32'sd0,         8'd0,   1'b0, RSP_OK}
	};

	// Shadow copy of the list and the results still owed by the block
	logic signed [cle_pkg::DATA_W-1:0] list_mem [cle_pkg::DEPTH];
	int unsigned                       list_len = 0;
	rsp_t                              owed_rsp [$];

	// Sender side bookkeeping, applied alongside the payload
	logic drv_typed;
	rsp_t drv_exp;
	int   burst_left;

	// Receiver stall pattern
	int stall_left;
	int run_left;

	// Run statistics
	int n_fail       = 0;
	int n_items      = 0;
	int n_results    = 0;
	int n_full       = 0;
	int n_empty      = 0;
	int n_full_dumps = 0;

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Safety net against a hung handshake
	initial begin
		#3_000_000;
		$display("%0t: timeout with %0d results still owed", $realtime, owed_rsp.size());
		$display("tb_circular_list_engine_unit: FAIL");
		$finish;
	end

	// Apply one command to the shadow list; queue its results when asked to
	task automatic list_apply(input logic [cle_pkg::CMD_W-1:0] c,
		input logic signed [cle_pkg::DATA_W-1:0] v,
		input logic [cle_pkg::POS_W-1:0] p, input logic queue_results);
		int unsigned                       slot;
		int unsigned                       i;
		logic signed [cle_pkg::DATA_W-1:0] taken;
		rsp_t                              r;
		case (c)
			cle_pkg::CMD_INS_END, cle_pkg::CMD_INS_FRONT, cle_pkg::CMD_INS_POS: begin
				if (list_len >= cle_pkg::DEPTH) begin
					r = RSP_FULL;
					if (queue_results) owed_rsp.push_back(r);
				end else begin
					if (list_len == 0 || c == cle_pkg::CMD_INS_END)
						slot = list_len;
					else if (c == cle_pkg::CMD_INS_FRONT)
						slot = 0;
					else if (p <= 1)
						slot = 1;
					else
						slot = ((int'(p) - 1) % list_len) + 1;
					for (i = list_len; i > slot; i--)
						list_mem[i] = list_mem[i-1];
					list_mem[slot] = v;
					list_len++;
					if (queue_results) owed_rsp.push_back(RSP_OK);
				end
			end
			cle_pkg::CMD_DEL_END, cle_pkg::CMD_DEL_FRONT: begin
				if (list_len == 0) begin
					if (queue_results) owed_rsp.push_back(RSP_EMPTY);
				end else begin
					if (c == cle_pkg::CMD_DEL_END) begin
						taken = list_mem[list_len-1];
					end else begin
						taken = list_mem[0];
						for (i = 1; i < list_len; i++)
							list_mem[i-1] = list_mem[i];
					end
					list_len--;
					r = '{cle_pkg::ST_OK, taken, 1'b1};
					if (queue_results) owed_rsp.push_back(r);
				end
			end
			cle_pkg::CMD_DUMP: begin
				if (list_len == 0) begin
					if (queue_results) owed_rsp.push_back(RSP_EMPTY);
				end else begin
					for (i = 0; i < list_len; i++) begin
						r = '{cle_pkg::ST_OK, list_mem[i], logic'(i + 1 == list_len)};
						if (queue_results) owed_rsp.push_back(r);
					end
				end
			end
			default: begin
				// spare codes: no results, list untouched
			end
		endcase
	endtask

	// Monitor: predict on each accepted request, check each accepted response
	always @(posedge clk) begin : monitor
		rsp_t want;
		if (req_ch.valid && req_ch.ready) begin
			if (req_ch.cmd == cle_pkg::CMD_DUMP && list_len == cle_pkg::DEPTH) n_full_dumps++;
			list_apply(req_ch.cmd, req_ch.item_value, req_ch.position, !drv_typed);
			if (drv_typed) owed_rsp.push_back(drv_exp);
			n_items++;
		end
		if (rsp_ch.valid && rsp_ch.ready) begin
			n_results++;
			if (owed_rsp.size() == 0) begin
				$display("%0t: unexpected transaction status=%0d value=%0d last=%0b",
					$realtime, rsp_ch.status, rsp_ch.out_value, rsp_ch.last);
				n_fail++;
			end else begin
				want = owed_rsp.pop_front();
				if (rsp_ch.status == cle_pkg::ST_FULL) n_full++;
				if (rsp_ch.status == cle_pkg::ST_EMPTY) n_empty++;
				if (rsp_ch.status !== want.status) begin
					$display("%0t: status mismatch, expected %0d got %0d",
						$realtime, want.status, rsp_ch.status);
					n_fail++;
				end
				if (rsp_ch.out_value !== want.value) begin
					$display("%0t: out_value mismatch, expected %0d got %0d",
						$realtime, want.value, rsp_ch.out_value);
					n_fail++;
				end
				if (rsp_ch.last !== want.last) begin
					$display("%0t: last mismatch, expected %0b got %0b",
						$realtime, want.last, rsp_ch.last);
					n_fail++;
				end
			end
		end
	end

	// Receiver: ready runs and stalls of random length, long ready stretches now and then
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left = 0;
			run_left   = 0;
		end else if (stall_left != 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left--;
		end else if (run_left != 0) begin
			rsp_ch.ready <= 1'b1;
			run_left--;
		end else begin
			run_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(0, 10);
			stall_left = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 30)
				: $urandom_range(0, 4);
			rsp_ch.ready <= (stall_left == 0);
		end
	end

	// Sender: one transaction, preceded by a random gap when a burst runs out
	task automatic send_txn(input logic [cle_pkg::CMD_W-1:0] c,
		input logic signed [cle_pkg::DATA_W-1:0] v,
		input logic [cle_pkg::POS_W-1:0] p, input logic typed, input rsp_t exp);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 5) == 0) ? 100 : $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_ch.valid      <= 1'b1;
		req_ch.cmd        <= c;
		req_ch.item_value <= v;
		req_ch.position   <= p;
		drv_typed         <= typed;
		drv_exp           <= exp;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Hold the request side idle until every owed result has arrived
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (owed_rsp.size() != 0) @(posedge clk);
	endtask

	// Main stimulus
	initial begin : stimulus
		logic [cle_pkg::CMD_W-1:0]         c;
		logic signed [cle_pkg::DATA_W-1:0] v;
		logic [cle_pkg::POS_W-1:0]         p;
		int                                sent;
		int                                phase_mode;
		int                                phase_left;
		int                                roll;

		arst_n            <= 1'b0;
		req_ch.valid      <= 1'b0;
		req_ch.cmd        <= cle_pkg::CMD_INS_END;
		req_ch.item_value <= '0;
		req_ch.position   <= '0;
		drv_typed         <= 1'b0;
		drv_exp           <= RSP_OK;
		burst_left = 0;
		phase_left = 0;
		phase_mode = 0;
		sent       = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part
		foreach (dir_rows[k])
			send_txn(dir_rows[k].cmd, dir_rows[k].value, dir_rows[k].pos,
				dir_rows[k].typed, dir_rows[k].exp);

		// Random part: fill, drain and mixed phases so the list swings between empty and full
		while (sent < N_RANDOM) begin
			if (phase_left == 0) begin
				phase_mode = $urandom_range(0, 2);
				phase_left = $urandom_range(8, 40);
			end
			phase_left--;

			roll = $urandom_range(0, 99);
			if (roll < 3)
				c = cle_pkg::CMD_W'($urandom_range(CMD_SPARE_6, CMD_SPARE_7));
			else if (roll < 13)
				c = cle_pkg::CMD_DUMP;
			else if ((phase_mode == 0 && roll < 85) || (phase_mode == 1 && roll >= 85)
				|| (phase_mode == 2 && roll < 56))
				c = cle_pkg::CMD_W'($urandom_range(cle_pkg::CMD_INS_END, cle_pkg::CMD_INS_POS));
			else
				c = cle_pkg::CMD_W'($urandom_range(cle_pkg::CMD_DEL_END,
					cle_pkg::CMD_DEL_FRONT));

			case ($urandom_range(0, 7))
				0: v = 32'sh7FFF_FFFF;
				1: v = 32'sh8000_0000;
				2: v = ($urandom_range(0, 1) == 0) ? 32'sd0 : -32'sd1;
				default: v = $urandom;
			endcase

			case ($urandom_range(0, 5))
				0: p = 8'd0;
				1: p = 8'd1;
				2: p = 8'd255;
				3, 4: p = cle_pkg::POS_W'($urandom_range(2, 20));
				default: p = cle_pkg::POS_W'($urandom_range(0, 255));
			endcase

			send_txn(c, v, p, 1'b0, RSP_OK);
			if (c <= cle_pkg::CMD_DUMP) begin
				sent++;
				if (sent % 125 == 0) wait_drained();
			end
		end

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Covered %0d requests and %0d checked responses, %0d full refusals,",
			n_items, n_results, n_full);
		$display("%0d empty answers and %0d dumps of a full list.", n_empty, n_full_dumps);
		if (n_fail == 0) begin
			$display("tb_circular_list_engine_unit: PASS");
		end else begin
			$display("tb_circular_list_engine_unit: FAIL");
		end
		$finish;
	end

endmodule
